@@ src/lfu_pkg.sv @@
// shared constants and types for the lfu cache engine
package lfu_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int KEY_W          = 32;
  localparam int CAP_W          = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic hit;
    logic free_ok;
    logic victim_ok;
  } sel_flags_t;

endpackage

@@ src/lfu_if.sv @@
// handshake channels for requests, results and the capacity register
interface lfu_req_if;
  import lfu_pkg::*;
  logic                    valid;
  logic                    ready;
  req_kind_t               req_type;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] value;
  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [KEY_W-1:0] read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;
  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if;
  import lfu_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_in_use;
  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

@@ src/lfu_lookup.sv @@
// key match, lowest free slot and victim search over all slots
module lfu_lookup #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic [ENTRIES-1:0]       slot_valid,
  input  logic [lfu_pkg::KEY_W-1:0] slot_key     [ENTRIES],
  input  logic [COUNT_BITS-1:0]    use_count    [ENTRIES],
  input  logic [IDX_W-1:0]         recency_rank [ENTRIES],
  input  logic [lfu_pkg::KEY_W-1:0] key,
  output logic [ENTRIES-1:0]       hit_oh,
  output logic [ENTRIES-1:0]       free_oh,
  output logic [IDX_W-1:0]         victim_idx,
  output lfu_pkg::sel_flags_t      flags
);
  import lfu_pkg::*;

  localparam int LEAVES = 1 << IDX_W;
  localparam int NODES  = 2 * LEAVES - 1;

  logic [ENTRIES-1:0]    match;
  logic                  nd_ok  [NODES];
  logic [COUNT_BITS-1:0] nd_cnt [NODES];
  logic [IDX_W-1:0]      nd_rnk [NODES];
  logic [IDX_W-1:0]      nd_idx [NODES];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = slot_valid[i] && (slot_key[i] == key);
    end
  end

  // keep the lowest set bit
  assign hit_oh  = match & (~match + ENTRIES'(1));
  assign free_oh = ~slot_valid & (slot_valid + ENTRIES'(1));

  // minimum tree: lowest count, then oldest rank
  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < ENTRIES) begin : g_real
      assign nd_ok[LEAVES-1+g]  = slot_valid[g];
      assign nd_cnt[LEAVES-1+g] = use_count[g];
      assign nd_rnk[LEAVES-1+g] = recency_rank[g];
    end else begin : g_pad
      assign nd_ok[LEAVES-1+g]  = 1'b0;
      assign nd_cnt[LEAVES-1+g] = '0;
      assign nd_rnk[LEAVES-1+g] = '0;
    end
    assign nd_idx[LEAVES-1+g] = IDX_W'(g);
  end

  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    logic pick_r;
    assign pick_r = nd_ok[2*n+2] && (!nd_ok[2*n+1] ||
                    (nd_cnt[2*n+2] < nd_cnt[2*n+1]) ||
                    ((nd_cnt[2*n+2] == nd_cnt[2*n+1]) &&
                     (nd_rnk[2*n+2] > nd_rnk[2*n+1])));
    assign nd_ok[n]  = nd_ok[2*n+1] || nd_ok[2*n+2];
    assign nd_cnt[n] = pick_r ? nd_cnt[2*n+2] : nd_cnt[2*n+1];
    assign nd_rnk[n] = pick_r ? nd_rnk[2*n+2] : nd_rnk[2*n+1];
    assign nd_idx[n] = pick_r ? nd_idx[2*n+2] : nd_idx[2*n+1];
  end

  assign victim_idx      = nd_idx[0];
  assign flags.hit       = |match;
  assign flags.free_ok   = |free_oh;
  assign flags.victim_ok = nd_ok[0];

endmodule

@@ src/lfu_cache_engine_core.sv @@
// top level of the lfu cache engine with lru tie-break
//
// channels: req carries one word per request (req_type get or put, key,
// value); rsp returns one word per request (hit, read_value, evicted,
// evicted_key); cfg writes capacity_in_use and is always ready.
// a request taken into the request stage is looked up and applied there, and
// its result is written to the output register as the stage advances; the
// request stage and the output register lie between acceptance and rsp.valid.
// throughput is one request per cycle while rsp is not stalled; the key
// compare over all slots and the count/age minimum tree sit between them.
// a request sees every change made by the one before it.
// reset clears all valid marks, ages and the occupancy and sets the
// capacity to 16; keys, values and counts are written when a slot is loaded.
// when rsp is stalled the output word holds, the request stage holds its
// word and req.ready drops once both are full.
// capacity writes are expected only while no request is in flight.
module lfu_cache_engine_core #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lfu_cfg_if.sink   cfg,
  lfu_req_if.sink   req,
  lfu_rsp_if.source rsp
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // capacity register
  logic [CAP_W-1:0] capacity;

  // slot store
  logic [ENTRIES-1:0]    slot_valid;
  logic [KEY_W-1:0]      slot_key     [ENTRIES];
  logic [KEY_W-1:0]      slot_data    [ENTRIES];
  logic [COUNT_BITS-1:0] use_count    [ENTRIES];
  logic [IDX_W-1:0]      recency_rank [ENTRIES];
  logic [OCC_W-1:0]      occupancy;

  // request stage
  logic             s1_valid;
  req_kind_t        s1_req_type;
  logic [KEY_W-1:0] s1_key;
  logic [KEY_W-1:0] s1_value;

  // result register
  logic             out_valid;
  logic             out_hit;
  logic [KEY_W-1:0] out_read_value;
  logic             out_evicted;
  logic [KEY_W-1:0] out_evicted_key;

  logic             advance;
  logic             fire;

  logic [ENTRIES-1:0] hit_oh;
  logic [ENTRIES-1:0] free_oh;
  logic [IDX_W-1:0]   victim_idx;
  sel_flags_t         flags;

  logic [CMP_W-1:0] cap_eff;
  logic             is_put;
  logic             cap_zero;
  logic             hit_ok;
  logic             miss_put;
  logic             do_fill;
  logic             do_evict;
  logic [KEY_W-1:0] hit_data;
  logic [IDX_W-1:0] hit_rank;
  logic [IDX_W-1:0] old_rank;

  logic [ENTRIES-1:0] victim_oh;
  logic [ENTRIES-1:0] bump;
  logic [ENTRIES-1:0] load;
  logic [ENTRIES-1:0] data_wr;
  logic [ENTRIES-1:0] to_front;
  logic [ENTRIES-1:0] age;

  assign cfg.ready = 1'b1;

  assign advance   = !out_valid || rsp.ready;
  assign fire      = s1_valid && advance;
  assign req.ready = !s1_valid || advance;

  lfu_lookup #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_lookup (
    .slot_valid   (slot_valid),
    .slot_key     (slot_key),
    .use_count    (use_count),
    .recency_rank (recency_rank),
    .key          (s1_key),
    .hit_oh       (hit_oh),
    .free_oh      (free_oh),
    .victim_idx   (victim_idx),
    .flags        (flags)
  );

  // capacity above the slot count acts as the slot count
  assign cap_eff = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                        : CMP_W'(capacity);

  assign is_put   = (s1_req_type == REQ_PUT);
  assign cap_zero = (capacity == '0);
  assign hit_ok   = flags.hit && !(is_put && cap_zero);
  assign miss_put = is_put && !cap_zero && !flags.hit;
  assign do_fill  = miss_put && (CMP_W'(occupancy) < cap_eff) && flags.free_ok;
  assign do_evict = miss_put && !do_fill && flags.victim_ok;

  always_comb begin
    hit_data = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh[i]) begin
        hit_data = hit_data | slot_data[i];
        hit_rank = hit_rank | recency_rank[i];
      end
      victim_oh[i] = (victim_idx == IDX_W'(i));
    end
  end

  assign old_rank = hit_ok ? hit_rank : recency_rank[victim_idx];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      bump[i]     = fire && hit_ok && hit_oh[i];
      load[i]     = fire && ((do_fill && free_oh[i]) || (do_evict && victim_oh[i]));
      data_wr[i]  = load[i] || (bump[i] && is_put);
      to_front[i] = bump[i] || load[i];
      // slots newer than the touched one age; a fill ages every other valid slot
      age[i]      = fire && slot_valid[i] && !to_front[i] &&
                    (do_fill || ((hit_ok || do_evict) && (recency_rank[i] < old_rank)));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      slot_valid <= '0;
      occupancy  <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.capacity_in_use;
      end
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (fire && do_fill) begin
        slot_valid <= slot_valid | free_oh;
        occupancy  <= occupancy + OCC_W'(1);
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (to_front[i]) begin
          recency_rank[i] <= '0;
        end else if (age[i]) begin
          recency_rank[i] <= recency_rank[i] + IDX_W'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req_type <= req.req_type;
      s1_key      <= req.key;
      s1_value    <= req.value;
    end
    if (fire) begin
      out_hit         <= hit_ok;
      out_read_value  <= (hit_ok && !is_put) ? hit_data : '0;
      out_evicted     <= do_evict;
      out_evicted_key <= do_evict ? slot_key[victim_idx] : '0;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (load[i]) begin
        slot_key[i]  <= s1_key;
        use_count[i] <= COUNT_BITS'(1);
      end else if (bump[i] && (use_count[i] != '1)) begin
        use_count[i] <= use_count[i] + COUNT_BITS'(1);
      end
      if (data_wr[i]) begin
        slot_data[i] <= s1_value;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.read_value  = out_read_value;
  assign rsp.evicted     = out_evicted;
  assign rsp.evicted_key = out_evicted_key;

endmodule

@@ src/lfu_checker.sv @@
// port-level checks on the lfu cache engine, bound to the top level
module lfu_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic                      rsp_hit,
  input logic [lfu_pkg::KEY_W-1:0] rsp_read_value,
  input logic                      rsp_evicted,
  input logic [lfu_pkg::KEY_W-1:0] rsp_evicted_key
);
  import lfu_pkg::*;

  // a stalled result must stay valid, and its read value and evicted key must not change
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_evicted_key) &&
                                $stable(rsp_read_value))
    else $error("result word changed while stalled");

  // nothing is delivered straight out of reset
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid just after reset");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_hit && rsp_evicted))
    else $error("hit and eviction in one result");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> rsp_read_value == '0)
    else $error("read value on a miss");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
    else $error("evicted key without eviction");

endmodule

bind lfu_cache_engine_core lfu_checker u_lfu_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_hit         (rsp.hit),
  .rsp_read_value  (rsp.read_value),
  .rsp_evicted     (rsp.evicted),
  .rsp_evicted_key (rsp.evicted_key)
);
